// File: hw/rtl/apq_pkg.sv
// Package for the array priority queue: request/result item types,
// mode and status codes, datapath command and status types.
// No dependencies; used by apq_ctrl, apq_datapath and array_priority_queue_core.
package apq_pkg;

	// Default configuration
	localparam int APQ_DEPTH         = 8;
	localparam int APQ_PRIORITY_BITS = 8;

	// Request modes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_REPORT = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// One request item
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] element;
		logic [7:0]         priority_req;
	} apq_request_t;

	// One result item
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_element;
		logic [7:0]         removed_priority;
		logic [3:0]         count;
		logic [7:0]         top_priority;
		logic               is_empty;
		logic               is_full;
	} apq_result_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} apq_state_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INSERT,
		OP_REJECT_FULL,
		OP_REJECT_EMPTY,
		OP_REPORT,
		OP_SCAN_START,
		OP_SCAN,
		OP_SHIFT,
		OP_FINISH
	} apq_op_t;

	typedef struct packed {
		apq_op_t op;
	} apq_dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;
		logic shift_done;
	} apq_dp_status_t;

endpackage

// File: hw/rtl/array_priority_queue_core.sv
// Array priority queue: holds up to DEPTH element/priority pairs in arrival
// order. An item is taken when start is high and busy is low. Insert, report
// and rejected requests keep busy low, so one such item can be taken every
// cycle; its result appears with done on the next cycle. A removal scans the
// occupied entries through the single read port of the entry memory, then
// shifts the entries behind the removed one forward one slot per cycle,
// keeping busy high throughout; its result appears with done in the cycle
// in which busy falls. done is high for exactly one cycle per item and the
// receiver cannot hold it off, so result must be captured in that cycle.
// Priorities are unsigned; the oldest of equal top priorities is removed
// first. No clearing pass is needed after reset.
module array_priority_queue_core #(
	parameter int DEPTH         = apq_pkg::APQ_DEPTH,
	parameter int PRIORITY_BITS = apq_pkg::APQ_PRIORITY_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  apq_pkg::apq_request_t request,
	output logic                  done,
	output apq_pkg::apq_result_t  result
);
	import apq_pkg::*;

	apq_dp_cmd_t    dp_cmd;
	apq_dp_status_t dp_status;

	// Sequencing
	apq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (request.mode),
		.dp_status (dp_status),
		.busy      (busy),
		.dp_cmd    (dp_cmd)
	);

	// Storage, compare and result
	apq_datapath #(
		.DEPTH         (DEPTH),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.done      (done),
		.result    (result)
	);

endmodule

// File: hw/rtl/apq_ctrl.sv
// Controller state machine of the array priority queue.
// Decodes each accepted item and sequences the scan and shift of a removal.
// Depends on apq_pkg.
module apq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             mode,
	input  apq_pkg::apq_dp_status_t dp_status,
	output logic                   busy,
	output apq_pkg::apq_dp_cmd_t   dp_cmd
);
	import apq_pkg::*;

	apq_state_t state_q;
	apq_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath command
	always_comb begin
		state_d   = state_q;
		dp_cmd.op = OP_NONE;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (mode)
						MODE_INSERT: begin
							dp_cmd.op = dp_status.full ? OP_REJECT_FULL : OP_INSERT;
						end
						MODE_REMOVE: begin
							if (dp_status.empty) begin
								dp_cmd.op = OP_REJECT_EMPTY;
							end else begin
								dp_cmd.op = OP_SCAN_START;
								state_d   = ST_SCAN;
							end
						end
						default: begin
							// report, and the unused mode code
							dp_cmd.op = OP_REPORT;
						end
					endcase
				end
			end
			ST_SCAN: begin
				dp_cmd.op = OP_SCAN;
				if (dp_status.scan_done) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (dp_status.shift_done) begin
					dp_cmd.op = OP_FINISH;
					state_d   = ST_IDLE;
				end else begin
					dp_cmd.op = OP_SHIFT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/apq_datapath.sv
// Datapath of the array priority queue: entry memory, occupancy, scan
// compare unit, shift sequencing and the registered result.
// Depends on apq_pkg; driven by apq_ctrl.
module apq_datapath #(
	parameter int DEPTH         = apq_pkg::APQ_DEPTH,
	parameter int PRIORITY_BITS = apq_pkg::APQ_PRIORITY_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  apq_pkg::apq_request_t   request,
	input  apq_pkg::apq_dp_cmd_t    dp_cmd,
	output apq_pkg::apq_dp_status_t dp_status,
	output logic                    done,
	output apq_pkg::apq_result_t    result
);
	import apq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = PRIORITY_BITS;

	// Entry memory, one write and one read port
	logic signed [31:0] mem_elem [DEPTH];
	logic [PW-1:0]      mem_prio [DEPTH];

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic [PW-1:0]      top_q;
	logic               rd_valid_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic signed [31:0] rd_elem_s1;
	logic [PW-1:0]      rd_prio_s1;
	logic [PW-1:0]      best_prio_q;
	logic [IW-1:0]      best_idx_q;
	logic signed [31:0] best_elem_q;
	logic [PW-1:0]      second_q;
	logic               done_q;
	apq_result_t        result_q;

	logic [PW-1:0]      prio_in;
	logic [CW:0]        ptr_inc;
	logic               scan_issue;
	logic               shift_issue;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               cmp_en;
	logic               take_s1;
	logic [IW-1:0]      best_idx_d;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic signed [31:0] wr_elem;
	logic [PW-1:0]      wr_prio;
	logic [PW-1:0]      ins_top;
	logic [CW-1:0]      count_inc;
	logic [CW-1:0]      count_dec;
	logic [CW-1:0]      res_count_d;
	logic [PW-1:0]      res_top_d;
	logic [1:0]         res_status_d;
	logic               res_removed;
	logic               done_d;

	assign prio_in   = PW'(request.priority_req);
	assign ptr_inc   = {1'b0, ptr_q} + (CW + 1)'(1);
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign ins_top   = (prio_in > top_q) ? prio_in : top_q;

	// Read port addressing: scan walks up from the head, shift reads one ahead
	assign scan_issue  = (dp_cmd.op == OP_SCAN) && (ptr_q < count_q);
	assign shift_issue = (dp_cmd.op == OP_SHIFT) && (ptr_inc < {1'b0, count_q});
	assign rd_en       = (dp_cmd.op == OP_SCAN_START) || scan_issue || shift_issue;

	always_comb begin
		rd_addr = '0;
		if (scan_issue) begin
			rd_addr = ptr_q[IW-1:0];
		end else if (shift_issue) begin
			rd_addr = ptr_inc[IW-1:0];
		end
	end

	// Compare stage: head entry always taken, later ones only if strictly higher
	assign cmp_en     = (dp_cmd.op == OP_SCAN) && rd_valid_s1;
	assign take_s1    = (rd_idx_s1 == '0) || (rd_prio_s1 > best_prio_q);
	assign best_idx_d = (cmp_en && take_s1) ? rd_idx_s1 : best_idx_q;

	// Write port: tail insert, or shift of the entry held in the read register
	assign wr_en = (dp_cmd.op == OP_INSERT) || ((dp_cmd.op == OP_SHIFT) && rd_valid_s1);

	always_comb begin
		if (dp_cmd.op == OP_INSERT) begin
			wr_addr = count_q[IW-1:0];
			wr_elem = request.element;
			wr_prio = prio_in;
		end else begin
			wr_addr = rd_idx_s1 - IW'(1);
			wr_elem = rd_elem_s1;
			wr_prio = rd_prio_s1;
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_elem[wr_addr] <= wr_elem;
			mem_prio[wr_addr] <= wr_prio;
		end
		if (rd_en) begin
			rd_elem_s1 <= mem_elem[rd_addr];
			rd_prio_s1 <= mem_prio[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Status back to the controller
	assign dp_status.full       = (count_q == CW'(DEPTH));
	assign dp_status.empty      = (count_q == '0);
	assign dp_status.scan_done  = rd_valid_s1 && (ptr_q == count_q);
	assign dp_status.shift_done = !rd_valid_s1 && (ptr_inc >= {1'b0, count_q});

	// Result selection
	always_comb begin
		res_count_d  = count_q;
		res_top_d    = top_q;
		res_status_d = STAT_OK;
		res_removed  = 1'b0;
		case (dp_cmd.op)
			OP_INSERT: begin
				res_count_d = count_inc;
				res_top_d   = ins_top;
			end
			OP_REJECT_FULL: begin
				res_status_d = STAT_FULL;
			end
			OP_REJECT_EMPTY: begin
				res_status_d = STAT_EMPTY;
			end
			OP_FINISH: begin
				res_count_d = count_dec;
				res_top_d   = second_q;
				res_removed = 1'b1;
			end
			default: begin
			end
		endcase
		done_d = dp_cmd.op inside {OP_INSERT, OP_REJECT_FULL, OP_REJECT_EMPTY,
			OP_REPORT, OP_FINISH};
	end

	// Control registers: occupancy, top priority, pointer, read valid, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			top_q       <= '0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			done_q      <= done_d;
			case (dp_cmd.op)
				OP_INSERT: begin
					count_q <= count_inc;
					top_q   <= ins_top;
				end
				OP_FINISH: begin
					count_q <= count_dec;
					top_q   <= second_q;
				end
				OP_SCAN_START: begin
					ptr_q <= CW'(1);
				end
				OP_SCAN: begin
					if (scan_issue) begin
						ptr_q <= ptr_inc[CW-1:0];
					end else if (dp_status.scan_done) begin
						// shift starts at the slot being removed
						ptr_q <= CW'(best_idx_d);
					end
				end
				OP_SHIFT: begin
					if (shift_issue) begin
						ptr_q <= ptr_inc[CW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Best and runner-up tracking during the scan
	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_SCAN_START) begin
			second_q <= '0;
		end else if (cmp_en) begin
			if (rd_idx_s1 == '0) begin
				best_prio_q <= rd_prio_s1;
				best_elem_q <= rd_elem_s1;
			end else if (rd_prio_s1 > best_prio_q) begin
				second_q    <= best_prio_q;
				best_prio_q <= rd_prio_s1;
				best_elem_q <= rd_elem_s1;
			end else if (rd_prio_s1 > second_q) begin
				second_q <= rd_prio_s1;
			end
		end
		best_idx_q <= best_idx_d;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (done_d) begin
			result_q.status           <= res_status_d;
			result_q.removed_element  <= res_removed ? best_elem_q : 32'sd0;
			result_q.removed_priority <= res_removed ? 8'(best_prio_q) : 8'd0;
			result_q.count            <= 4'(res_count_d);
			result_q.top_priority     <= 8'(res_top_d);
			result_q.is_empty         <= (res_count_d == '0);
			result_q.is_full          <= (res_count_d == CW'(DEPTH));
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (top_q == '0))
		else $error("top priority nonzero on empty queue");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_en |-> ({1'b0, rd_idx_s1} < {1'b0, count_q}))
		else $error("scan compared an entry beyond occupancy");

	a_shift_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == OP_SCAN && dp_status.scan_done) |=> !rd_valid_s1)
		else $error("read pending when shift begins");
`endif

endmodule
